// ===== src/ift_pkg.sv =====
// Shared constants and helpers for the IR frame pulse transmitter.
package ift_pkg;

  localparam int TICK_W  = 16;
  localparam int FRAME_W = 16;
  localparam int FIELD_W = 5;
  localparam int QUEUED_W = 5;
  localparam int BITS_W  = 4;

  localparam logic [TICK_W-1:0] LONG_RESET  = 16'd1600;
  localparam logic [TICK_W-1:0] SHORT_RESET = 16'd800;
  localparam logic [TICK_W-1:0] GAP_RESET   = 16'd3000;

  localparam logic [FRAME_W-1:0] FRAME_START = 16'h8000;
  localparam logic [BITS_W-1:0]  LAST_BIT    = 4'd15;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MARK  = 2'd1;
  localparam logic [1:0] PH_SPACE = 2'd2;
  localparam logic [1:0] PH_GAP   = 2'd3;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_LONG  = 2'd0;
  localparam logic [1:0] REG_SHORT = 2'd1;
  localparam logic [1:0] REG_GAP   = 2'd2;

  // ticks left after the first tick of a part; zero length counts as one
  function automatic logic [TICK_W-1:0] rest_of(input logic [TICK_W-1:0] len);
    rest_of = (len == '0) ? '0 : len - 1'b1;
  endfunction

  function automatic logic [FRAME_W-1:0] build_frame(input logic [FIELD_W-1:0] plr,
                                                     input logic [FIELD_W-1:0] dat);
    build_frame = FRAME_START | {1'b0, plr, dat, plr ^ dat};
  endfunction

endpackage

// ===== src/ir_frame_pulse_transmitter.sv =====
// Top level of the IR frame pulse transmitter: frame FIFO, envelope timer, APB registers.
//
// Input channel (item_valid/item_ready): func 0 enqueues a frame built from player
// and payload (twice when repeat_req is set), func 1 is one timer tick of the LED
// envelope. Every input transaction gives exactly one result transaction on the
// res_valid/res_ready channel: led_on, busy_res, accepted and queued.
// The result is registered at the edge that accepts the item. Throughput is one item
// per cycle while item_ready is high. A repeated enqueue writes its second FIFO copy
// in the following cycle through the single RAM write port, so item_ready is low
// for that one cycle.
// The result register is a single stage; when the receiver stalls, item_ready
// falls until the waiting result is taken, and nothing is dropped.
// Reset (rst, synchronous) empties the FIFO, idles the envelope and loads the tick
// lengths 1600/800/3000. The FIFO RAM needs no clearing.
// APB registers: 0x0 long_ticks, 0x4 short_ticks, 0x8 gap_ticks; write only
// while no transaction is in flight. A new length applies from the next part.
module ir_frame_pulse_transmitter #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic                            func,
  input  logic [ift_pkg::FIELD_W-1:0]     player,
  input  logic [ift_pkg::FIELD_W-1:0]     payload,
  input  logic                            repeat_req,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic                            led_on,
  output logic                            busy_res,
  output logic                            accepted,
  output logic [ift_pkg::QUEUED_W-1:0]    queued,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ift_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ift_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ift_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import ift_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // configuration
  logic [TICK_W-1:0] long_ticks;
  logic [TICK_W-1:0] short_ticks;
  logic [TICK_W-1:0] gap_ticks;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_ticks  <= LONG_RESET;
      short_ticks <= SHORT_RESET;
      gap_ticks   <= GAP_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LONG:  long_ticks  <= pwdata[TICK_W-1:0];
        REG_SHORT: short_ticks <= pwdata[TICK_W-1:0];
        REG_GAP:   gap_ticks   <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LONG:  prdata = {{(APB_DATA_W-TICK_W){1'b0}}, long_ticks};
      REG_SHORT: prdata = {{(APB_DATA_W-TICK_W){1'b0}}, short_ticks};
      REG_GAP:   prdata = {{(APB_DATA_W-TICK_W){1'b0}}, gap_ticks};
      default:   prdata = '0;
    endcase
  end

  // state
  logic [AW-1:0]      head, head_next;
  logic [AW-1:0]      tail, tail_next;
  logic [CW-1:0]      count, count_next;
  logic [FRAME_W-1:0] shift_word, shift_word_next;
  logic [BITS_W-1:0]  bit_left, bit_left_next;
  logic [1:0]         phase, phase_next;
  logic [TICK_W-1:0]  tick_left, tick_left_next;
  logic               load_pend, load_pend_next;
  logic               wr_pend, wr_pend_next;
  logic [AW-1:0]      pend_addr, pend_addr_next;
  logic [FRAME_W-1:0] pend_data, pend_data_next;

  logic               take;
  logic               acc;
  logic [CW:0]        need_sum;
  logic [FRAME_W-1:0] frame;
  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [FRAME_W-1:0] ram_wr_data;
  logic [FRAME_W-1:0] ram_rd_data;
  logic [CW+QUEUED_W-1:0] count_ext;

  assign item_ready = !wr_pend && (!res_valid || res_ready);
  assign take       = item_valid && item_ready;
  assign frame      = build_frame(player, payload);
  assign need_sum   = {1'b0, count} + (repeat_req ? (CW+1)'(2) : (CW+1)'(1));

  ift_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (head),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    shift_word_next = shift_word;
    bit_left_next   = bit_left;
    phase_next      = phase;
    tick_left_next  = tick_left;
    load_pend_next  = 1'b0;
    wr_pend_next    = 1'b0;
    pend_addr_next  = pend_addr;
    pend_data_next  = pend_data;
    acc             = 1'b0;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = pend_addr;
    ram_wr_data     = pend_data;

    // head word arrives in the cycle after the pop; the start bit stands in until then
    if (load_pend) begin
      shift_word_next = ram_rd_data;
    end

    if (wr_pend) begin
      ram_wr_en = 1'b1;
    end

    if (take && !func) begin
      if (need_sum <= (CW+1)'(FIFO_DEPTH)) begin
        acc         = 1'b1;
        ram_wr_en   = 1'b1;
        ram_wr_addr = tail;
        ram_wr_data = frame;
        if (repeat_req) begin
          wr_pend_next   = 1'b1;
          pend_addr_next = ptr_inc(tail);
          pend_data_next = frame;
          tail_next      = ptr_inc(ptr_inc(tail));
        end else begin
          tail_next = ptr_inc(tail);
        end
        count_next = need_sum[CW-1:0];
      end
    end else if (take && func) begin
      if (phase == PH_IDLE || (phase == PH_GAP && tick_left == '0)) begin
        if (count == '0) begin
          phase_next     = PH_IDLE;
          tick_left_next = '0;
        end else begin
          head_next       = ptr_inc(head);
          count_next      = count - 1'b1;
          bit_left_next   = LAST_BIT;
          shift_word_next = FRAME_START;
          load_pend_next  = 1'b1;
          phase_next      = PH_MARK;
          tick_left_next  = rest_of(long_ticks);
        end
      end else if (tick_left != '0) begin
        tick_left_next = tick_left - 1'b1;
      end else if (phase == PH_MARK) begin
        phase_next     = PH_SPACE;
        tick_left_next = rest_of(shift_word[FRAME_W-1] ? short_ticks : long_ticks);
      end else if (bit_left != '0) begin
        bit_left_next   = bit_left - 1'b1;
        shift_word_next = {shift_word[FRAME_W-2:0], 1'b0};
        phase_next      = PH_MARK;
        tick_left_next  = rest_of(shift_word[FRAME_W-2] ? long_ticks : short_ticks);
      end else begin
        phase_next     = PH_GAP;
        tick_left_next = rest_of(gap_ticks);
      end
    end
  end

  assign count_ext = {{QUEUED_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      shift_word <= '0;
      bit_left   <= '0;
      phase      <= PH_IDLE;
      tick_left  <= '0;
      load_pend  <= 1'b0;
      wr_pend    <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      shift_word <= shift_word_next;
      bit_left   <= bit_left_next;
      phase      <= phase_next;
      tick_left  <= tick_left_next;
      load_pend  <= load_pend_next;
      wr_pend    <= wr_pend_next;
      if (take) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    pend_data <= pend_data_next;
    if (take) begin
      led_on   <= (phase_next == PH_MARK);
      busy_res <= (phase_next != PH_IDLE);
      accepted <= acc;
      queued   <= count_ext[QUEUED_W-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FIFO_DEPTH))
    else $error("frame count exceeds FIFO depth");

  a_load_in_mark: assert property (@(posedge clk) disable iff (rst)
    load_pend |-> phase == PH_MARK)
    else $error("head word load outside first mark");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    take && func && phase == PH_IDLE && count != '0 |=> load_pend && phase == PH_MARK)
    else $error("idle tick with queued frame did not start it");

  a_led_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && led_on |-> busy_res)
    else $error("LED on while not busy");

  a_acc_queued: assert property (@(posedge clk) disable iff (rst)
    take && !func && acc |=> count != '0)
    else $error("accepted enqueue left FIFO empty");

endmodule

// ===== src/ift_ram.sv =====
// Generic single write port RAM with registered read.
module ift_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
